### sv/bllp_pkg.sv
package bllp_pkg;

    localparam int X_BITS      = 9;
    localparam int Y_BITS      = 8;
    localparam int COORD_BITS  = 9;
    localparam int ROW_SHIFT   = 10;
    localparam int ERR_BITS    = COORD_BITS + 2;
    localparam int ADDR_BITS   = 32;
    localparam int COLOR_BITS  = 16;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_TICK = 1'b1;

    typedef struct packed {
        logic                  mode;
        logic [X_BITS-1:0]     start_x;
        logic [Y_BITS-1:0]     start_y;
        logic [X_BITS-1:0]     end_x;
        logic [Y_BITS-1:0]     end_y;
        logic [COLOR_BITS-1:0] color;
    } bllp_cmd_t;

    typedef struct packed {
        logic [X_BITS-1:0]     pixel_x;
        logic [Y_BITS-1:0]     pixel_y;
        logic [ADDR_BITS-1:0]  pixel_address;
        logic [COLOR_BITS-1:0] pixel_color;
        logic                  last_pixel;
    } bllp_pixel_t;

    // One classified request as it waits between the front and the back.
    typedef struct packed {
        logic                  is_load;
        logic                  steep;
        logic [COORD_BITS-1:0] major_pos;
        logic [COORD_BITS-1:0] major_end;
        logic [COORD_BITS-1:0] minor_pos;
        logic                  step_down;
        logic [COORD_BITS-1:0] major_delta;
        logic [COORD_BITS-1:0] minor_delta;
        logic [COLOR_BITS-1:0] color;
    } bllp_entry_t;

    typedef struct packed {
        logic valid;
        logic ready;
    } bllp_hs_t;

endpackage

### sv/bllp_front.sv
module bllp_front
    import bllp_pkg::*;
(
    input  bllp_cmd_t   cmd,
    output bllp_entry_t entry
);

    logic [COORD_BITS-1:0] x0, y0, x1, y1;
    logic [COORD_BITS-1:0] dx, dy;
    logic [COORD_BITS-1:0] a0, b0, a1, b1;
    logic [COORD_BITS-1:0] lo_a, lo_b, hi_a, hi_b;
    logic                  steep;

    always_comb
    begin
        x0 = COORD_BITS'(cmd.start_x);
        y0 = COORD_BITS'(cmd.start_y);
        x1 = COORD_BITS'(cmd.end_x);
        y1 = COORD_BITS'(cmd.end_y);
        dx = (x1 >= x0) ? (x1 - x0) : (x0 - x1);
        dy = (y1 >= y0) ? (y1 - y0) : (y0 - y1);
        steep = (dy > dx);

        a0 = steep ? y0 : x0;
        b0 = steep ? x0 : y0;
        a1 = steep ? y1 : x1;
        b1 = steep ? x1 : y1;

        // Order the endpoints so that the major axis counts upward.
        if (a0 > a1)
        begin
            lo_a = a1;
            lo_b = b1;
            hi_a = a0;
            hi_b = b0;
        end
        else
        begin
            lo_a = a0;
            lo_b = b0;
            hi_a = a1;
            hi_b = b1;
        end

        entry.is_load     = (cmd.mode == MODE_LOAD);
        entry.steep       = steep;
        entry.major_pos   = lo_a;
        entry.major_end   = hi_a;
        entry.minor_pos   = lo_b;
        entry.step_down   = !(lo_b < hi_b);
        entry.major_delta = hi_a - lo_a;
        entry.minor_delta = (hi_b >= lo_b) ? (hi_b - lo_b) : (lo_b - hi_b);
        entry.color       = cmd.color;
    end

endmodule

### sv/bllp_queue.sv
module bllp_queue
    import bllp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  bllp_entry_t push_data,
    output logic        not_full,
    input  logic        pop,
    output logic        not_empty,
    output bllp_entry_t head
);

    bllp_entry_t          slots_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_BITS-1:0] count_reg, count_next;
    logic                 do_push, do_pop;

    assign not_full  = (count_reg != QCNT_BITS'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = slots_reg[rd_ptr_reg];
    assign do_push   = push && not_full;
    assign do_pop    = pop && not_empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### sv/bllp_back.sv
module bllp_back
    import bllp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [ADDR_BITS-1:0] cfg_base,
    input  logic                 q_valid,
    input  bllp_entry_t          q_head,
    output logic                 q_pop,
    output logic                 pix_valid,
    input  logic                 pix_ready,
    output bllp_pixel_t          pix
);

    logic [ADDR_BITS-1:0]         base_reg;
    logic                         line_active_reg, line_active_next;
    logic                         steep_reg, steep_next;
    logic [COORD_BITS-1:0]        major_pos_reg, major_pos_next;
    logic [COORD_BITS-1:0]        major_end_reg, major_end_next;
    logic [COORD_BITS-1:0]        minor_pos_reg, minor_pos_next;
    logic                         step_down_reg, step_down_next;
    logic [COORD_BITS-1:0]        major_delta_reg, major_delta_next;
    logic [COORD_BITS-1:0]        minor_delta_reg, minor_delta_next;
    logic signed [ERR_BITS-1:0]   error_reg, error_next;
    logic [COLOR_BITS-1:0]        color_reg, color_next;
    logic                         pix_valid_reg, pix_valid_next;
    bllp_pixel_t                  pix_reg, pix_next;

    logic                         out_free, emit, last;
    logic [COORD_BITS-1:0]        px, py;
    logic signed [ERR_BITS-1:0]   err_sum;

    assign out_free  = !pix_valid_reg || pix_ready;
    // A tick with no line running is dropped; an active tick waits for a free output slot.
    assign q_pop     = q_valid && (q_head.is_load || !line_active_reg || out_free);
    assign emit      = q_valid && !q_head.is_load && line_active_reg && out_free;
    assign pix_valid = pix_valid_reg;
    assign pix       = pix_reg;

    always_comb
    begin
        px      = steep_reg ? minor_pos_reg : major_pos_reg;
        py      = steep_reg ? major_pos_reg : minor_pos_reg;
        last    = (major_pos_reg == major_end_reg);
        err_sum = error_reg + $signed({2'b00, minor_delta_reg});

        line_active_next = line_active_reg;
        steep_next       = steep_reg;
        major_pos_next   = major_pos_reg;
        major_end_next   = major_end_reg;
        minor_pos_next   = minor_pos_reg;
        step_down_next   = step_down_reg;
        major_delta_next = major_delta_reg;
        minor_delta_next = minor_delta_reg;
        error_next       = error_reg;
        color_next       = color_reg;

        pix_valid_next = pix_ready ? 1'b0 : pix_valid_reg;
        pix_next       = pix_reg;

        if (q_pop && q_head.is_load)
        begin
            line_active_next = 1'b1;
            steep_next       = q_head.steep;
            major_pos_next   = q_head.major_pos;
            major_end_next   = q_head.major_end;
            minor_pos_next   = q_head.minor_pos;
            step_down_next   = q_head.step_down;
            major_delta_next = q_head.major_delta;
            minor_delta_next = q_head.minor_delta;
            error_next       = ERR_BITS'(0) - {3'b000, q_head.major_delta[COORD_BITS-1:1]};
            color_next       = q_head.color;
        end
        else if (emit)
        begin
            pix_valid_next        = 1'b1;
            pix_next.pixel_x      = X_BITS'(px);
            pix_next.pixel_y      = Y_BITS'(py);
            pix_next.pixel_address = base_reg + (ADDR_BITS'(py) << ROW_SHIFT)
                                   + (ADDR_BITS'(px) << 1);
            pix_next.pixel_color  = color_reg;
            pix_next.last_pixel   = last;

            if (err_sum > 0)
            begin
                minor_pos_next = step_down_reg ? (minor_pos_reg - 1'b1)
                                               : (minor_pos_reg + 1'b1);
                error_next     = err_sum - $signed({2'b00, major_delta_reg});
            end
            else
            begin
                error_next = err_sum;
            end

            if (last)
            begin
                line_active_next = 1'b0;
            end
            else
            begin
                major_pos_next = major_pos_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg        <= '0;
            line_active_reg <= 1'b0;
            steep_reg       <= 1'b0;
            major_pos_reg   <= '0;
            major_end_reg   <= '0;
            minor_pos_reg   <= '0;
            step_down_reg   <= 1'b0;
            major_delta_reg <= '0;
            minor_delta_reg <= '0;
            error_reg       <= '0;
            color_reg       <= '0;
            pix_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                base_reg <= cfg_base;
            end
            line_active_reg <= line_active_next;
            steep_reg       <= steep_next;
            major_pos_reg   <= major_pos_next;
            major_end_reg   <= major_end_next;
            minor_pos_reg   <= minor_pos_next;
            step_down_reg   <= step_down_next;
            major_delta_reg <= major_delta_next;
            minor_delta_reg <= minor_delta_next;
            error_reg       <= error_next;
            color_reg       <= color_next;
            pix_valid_reg   <= pix_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pix_reg <= pix_next;
    end

endmodule

### sv/bresenham_line_pixel_generator_unit.sv
// Bresenham line engine. A load request (mode 0) sets up a line from its two endpoints and
// color; each tick request (mode 1) yields the next pixel with its frame-buffer byte address
// (base + y*1024 + x*2) and a last flag, after which the engine goes idle. Ticks while idle
// and loads give no pixel; a load replaces any line in progress. Requests are classified by a
// front stage and pass through a two-entry queue to the stepping back end, which emits one
// pixel per clock from its output register, so one request is taken every cycle unless the
// pixel consumer stalls. An accepted tick is written into a queue slot; the back end steps
// on it once it is the queue head and the output is free, and registers the pixel. The base
// address register is written through the cfg port, which is always ready, and must only be
// changed while the engine is idle.
module bresenham_line_pixel_generator_unit
    import bllp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cmd_valid,
    output logic                 cmd_ready,
    input  bllp_cmd_t            cmd,
    output logic                 pix_valid,
    input  logic                 pix_ready,
    output bllp_pixel_t          pix,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [ADDR_BITS-1:0] cfg_data
);

    bllp_entry_t front_entry;
    bllp_entry_t q_head;
    bllp_hs_t    q_in;
    bllp_hs_t    q_out;

    assign cfg_ready   = 1'b1;
    assign q_in.valid  = cmd_valid;
    assign cmd_ready   = q_in.ready;

    bllp_front u_front (
        .cmd   (cmd),
        .entry (front_entry)
    );

    bllp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_in.valid),
        .push_data (front_entry),
        .not_full  (q_in.ready),
        .pop       (q_out.ready),
        .not_empty (q_out.valid),
        .head      (q_head)
    );

    bllp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_valid),
        .cfg_base  (cfg_data),
        .q_valid   (q_out.valid),
        .q_head    (q_head),
        .q_pop     (q_out.ready),
        .pix_valid (pix_valid),
        .pix_ready (pix_ready),
        .pix       (pix)
    );

endmodule

### sv/bllp_checker.sv
module bllp_checker
    import bllp_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 cmd_valid,
    input logic                 cmd_ready,
    input bllp_cmd_t            cmd,
    input logic                 pix_valid,
    input logic                 pix_ready,
    input bllp_pixel_t          pix,
    input logic                 cfg_valid,
    input logic                 cfg_ready,
    input logic [ADDR_BITS-1:0] cfg_data
);

    logic [ADDR_BITS-1:0] base_reg;
    logic [9:0]           addr_low;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            base_reg <= cfg_data;
        end
    end

    // The row term only touches bits from ROW_SHIFT upward, so the low bits follow base and x alone.
    assign addr_low = base_reg[9:0] + {pix.pixel_x, 1'b0};

    a_cfg_always_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("cfg port not ready");

    a_cmd_hold: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && !cmd_ready |=> cmd_valid && $stable(cmd))
        else $error("waiting request changed or dropped");

    a_pix_hold: assert property (@(posedge clk) disable iff (!rst_n)
        pix_valid && !pix_ready |=> pix_valid && $stable(pix))
        else $error("stalled pixel changed or dropped");

    a_addr_low: assert property (@(posedge clk) disable iff (!rst_n)
        pix_valid |-> pix.pixel_address[9:0] == addr_low)
        else $error("pixel address does not match column and base");

    a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_ready |-> !pix_valid || pix_ready || $stable(pix))
        else $error("pixel changed under a configuration write");

endmodule

bind bresenham_line_pixel_generator_unit bllp_checker u_bllp_checker (.*);
